FILE: rtl/mpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_pkg: shared types and constants of the mask pixel to RGBA8 unit
// Register indexes, channel numbering, configuration bundle and the
// per-channel scale operands passed from the front end to the divider.
// ----------------------------------------------------------------------------
package mpr_pkg;

	localparam int NUM_CH = 4;
	localparam int WORD_W = 32;
	localparam int NUM_W  = WORD_W + 8;   // value * 255 fits in 40 bits
	localparam int CH_W   = 8;
	localparam int BPP_W  = 6;
	localparam int IDX_W  = 3;

	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	localparam logic [IDX_W-1:0] REG_RED_MASK      = 3'd0;
	localparam logic [IDX_W-1:0] REG_GREEN_MASK    = 3'd1;
	localparam logic [IDX_W-1:0] REG_BLUE_MASK     = 3'd2;
	localparam logic [IDX_W-1:0] REG_ALPHA_MASK    = 3'd3;
	localparam logic [IDX_W-1:0] REG_ALPHA_PRESENT = 3'd4;
	localparam logic [IDX_W-1:0] REG_BPP           = 3'd5;

	localparam logic [BPP_W-1:0] BPP_DERIVE = 6'd0;
	localparam logic [BPP_W-1:0] BPP_8      = 6'd8;
	localparam logic [BPP_W-1:0] BPP_16     = 6'd16;
	localparam logic [BPP_W-1:0] BPP_24     = 6'd24;
	localparam logic [BPP_W-1:0] BPP_32     = 6'd32;

	localparam logic [CH_W-1:0] CH_FULL = 8'hFF;

	typedef struct packed {
		logic [NUM_CH-1:0][WORD_W-1:0] mask;
		logic                          alpha_present;
		logic [BPP_W-1:0]              bpp;
	} mpr_cfg_t;

	// Operands for one channel: numerator, divisor 2^run-1, and a flag that
	// forces the channel to full scale.
	typedef struct packed {
		logic [NUM_W-1:0]  num;
		logic [WORD_W-1:0] den;
		logic              force_max;
	} mpr_scale_t;

	typedef mpr_scale_t [NUM_CH-1:0] mpr_scale_vec_t;
	typedef logic [NUM_CH-1:0][CH_W-1:0] mpr_chan_vec_t;

endpackage

FILE: rtl/mpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_front: pixel cut, channel extraction and scale operand setup
// Three stages: width select and mask trailing-zero count, barrel shift of
// the masked pixel and the mask, then run length and value * 255.
// ----------------------------------------------------------------------------
module mpr_front import mpr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  mpr_cfg_t       cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [31:0]    pixel_word,
	output logic           out_valid,
	input  logic           out_ready,
	output mpr_scale_vec_t out_lanes
);

	// Count of trailing zeros in five halving steps; 32 for a zero word.
	function automatic logic [5:0] trail_zeros(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] v;
		logic [5:0]        n;
		v = x;
		n = '0;
		if (x == '0) begin
			n = 6'd32;
		end else begin
			if (v[15:0] == '0) begin
				n = n + 6'd16;
				v = v >> 16;
			end
			if (v[7:0] == '0) begin
				n = n + 6'd8;
				v = v >> 8;
			end
			if (v[3:0] == '0) begin
				n = n + 6'd4;
				v = v >> 4;
			end
			if (v[1:0] == '0) begin
				n = n + 6'd2;
				v = v >> 2;
			end
			if (v[0] == 1'b0) begin
				n = n + 6'd1;
			end
		end
		return n;
	endfunction

	logic                          v_s1, v_s2, v_s3;
	logic                          rdy_s1, rdy_s2, rdy_s3;
	logic [WORD_W-1:0]             pixel_s1;
	logic [NUM_CH-1:0][5:0]        shift_s1;
	logic [NUM_CH-1:0]             force_s1;
	logic [NUM_CH-1:0][WORD_W-1:0] value_s2;
	logic [NUM_CH-1:0][WORD_W-1:0] mshift_s2;
	logic [NUM_CH-1:0]             force_s2;
	mpr_scale_vec_t                lanes_s3;

	logic [WORD_W-1:0]             all_mask;
	logic [BPP_W-1:0]              width;
	logic [WORD_W-1:0]             pixel_cut;
	logic [NUM_CH-1:0][5:0]        shift_d;
	logic [NUM_CH-1:0]             force_d;
	logic [NUM_CH-1:0][WORD_W-1:0] value_d;
	logic [NUM_CH-1:0][WORD_W-1:0] mshift_d;
	mpr_scale_vec_t                lanes_d;

	// A stage takes a new beat when it is empty or its beat moves on.
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Stage 1: pixel width and trailing zeros of every mask.
	always_comb begin
		all_mask = cfg.mask[CH_RED] | cfg.mask[CH_GREEN] | cfg.mask[CH_BLUE]
			| cfg.mask[CH_ALPHA];
		if (cfg.bpp != BPP_DERIVE) begin
			width = cfg.bpp;
		end else if (all_mask == '0 || all_mask[31:16] != '0) begin
			width = BPP_32;
		end else if (all_mask[15:8] != '0) begin
			width = BPP_16;
		end else begin
			width = BPP_8;
		end
		case (width)
			BPP_32:  pixel_cut = pixel_word;
			BPP_24:  pixel_cut = {8'h00, pixel_word[23:0]};
			BPP_16:  pixel_cut = {16'h0000, pixel_word[15:0]};
			BPP_8:   pixel_cut = {24'h000000, pixel_word[7:0]};
			default: pixel_cut = '0;
		endcase
		for (int c = 0; c < NUM_CH; c++) begin
			shift_d[c] = trail_zeros(cfg.mask[c]);
			force_d[c] = (cfg.mask[c] == '0);
		end
		if (!cfg.alpha_present) begin
			force_d[CH_ALPHA] = 1'b1;
		end
	end

	// Stage 2: bring each channel and its mask down to bit zero.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			value_d[c]  = (pixel_s1 & cfg.mask[c]) >> shift_s1[c];
			mshift_d[c] = cfg.mask[c] >> shift_s1[c];
		end
	end

	// Stage 3: divisor from the run of ones, numerator value * 255.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			lanes_d[c].den       = ~({WORD_W{1'b1}} << trail_zeros(~mshift_s2[c]));
			lanes_d[c].num       = {value_s2[c], 8'h00} - {8'h00, value_s2[c]};
			lanes_d[c].force_max = force_s2[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			pixel_s1 <= pixel_cut;
			shift_s1 <= shift_d;
			force_s1 <= force_d;
		end
		if (rdy_s2) begin
			value_s2  <= value_d;
			mshift_s2 <= mshift_d;
			force_s2  <= force_s1;
		end
		if (rdy_s3) begin
			lanes_s3 <= lanes_d;
		end
	end

	assign out_valid = v_s3;
	assign out_lanes = lanes_s3;

	// A live channel always divides by an odd, nonzero 2^run-1.
	genvar g;
	for (g = 0; g < NUM_CH; g++) begin : g_chk
		a_den_odd: assert property (@(posedge clk) disable iff (!arst_n)
			v_s3 && !lanes_s3[g].force_max |-> lanes_s3[g].den[0])
			else $error("live channel has an even divisor");
	end

endmodule

FILE: rtl/mpr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpr_divider: pipelined restoring divider for four channels
// One quotient bit per stage over the 40-bit numerator; only the low eight
// quotient bits are kept. Zero masks and absent alpha read full scale.
// ----------------------------------------------------------------------------
module mpr_divider import mpr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mpr_scale_vec_t in_lanes,
	output logic           out_valid,
	input  logic           out_ready,
	output mpr_chan_vec_t  out_chan
);

	localparam int STEPS = NUM_W;

	typedef struct packed {
		logic [WORD_W-1:0] rem;
		logic [NUM_W-1:0]  num;
		logic [WORD_W-1:0] den;
		logic [CH_W-1:0]   quo;
		logic              force_max;
	} lane_t;

	typedef lane_t [NUM_CH-1:0] lane_vec_t;

	function automatic lane_t div_step(input lane_t l);
		lane_t             r;
		logic [WORD_W:0]   trial;
		r     = l;
		trial = {l.rem, l.num[NUM_W-1]};
		if (trial >= {1'b0, l.den}) begin
			r.rem = WORD_W'(trial - {1'b0, l.den});
			r.quo = {l.quo[CH_W-2:0], 1'b1};
		end else begin
			r.rem = trial[WORD_W-1:0];
			r.quo = {l.quo[CH_W-2:0], 1'b0};
		end
		r.num = {l.num[NUM_W-2:0], 1'b0};
		return r;
	endfunction

	logic [STEPS-1:0] vld_s;
	logic [STEPS-1:0] rdy;
	lane_vec_t        lane_s [STEPS];
	lane_vec_t        lane_in;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			lane_in[c].rem       = '0;
			lane_in[c].num       = in_lanes[c].num;
			lane_in[c].den       = in_lanes[c].den;
			lane_in[c].quo       = '0;
			lane_in[c].force_max = in_lanes[c].force_max;
		end
	end

	genvar k, c;
	for (k = 0; k < STEPS; k++) begin : g_stage
		lane_vec_t src;
		logic      src_vld;

		if (k == 0) begin : g_first
			assign src     = lane_in;
			assign src_vld = in_valid;
		end else begin : g_next
			assign src     = lane_s[k-1];
			assign src_vld = vld_s[k-1];
		end

		if (k == STEPS - 1) begin : g_last
			assign rdy[k] = !vld_s[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !vld_s[k] || rdy[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= src_vld;
			end
		end

		for (c = 0; c < NUM_CH; c++) begin : g_ch
			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					lane_s[k][c] <= div_step(src[c]);
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[STEPS-1];

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			out_chan[i] = lane_s[STEPS-1][i].force_max ? CH_FULL : lane_s[STEPS-1][i].quo;
		end
	end

	// The final remainder of a live channel is below its divisor.
	for (c = 0; c < NUM_CH; c++) begin : g_chk
		a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
			vld_s[STEPS-1] && !lane_s[STEPS-1][c].force_max
			|-> lane_s[STEPS-1][c].rem < lane_s[STEPS-1][c].den)
			else $error("divider remainder not below divisor");
	end

endmodule

FILE: rtl/mask_pixel_to_rgba8_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_pixel_to_rgba8_unit: bitmask pixel format to RGBA8 converter
// Converts one packed pixel word, laid out by four channel masks, into
// 8-bit red, green, blue and alpha values per beat.
// ----------------------------------------------------------------------------
// The unit takes one pixel beat per clock while in_ready is high and returns
// one RGBA beat per pixel, in order: three front stages cut the word and line
// each channel up, and a 40-stage restoring divider makes one quotient bit per
// stage for the value * 255 / (2^bits - 1) scaling. Stages with no beat close
// up while the output is stalled, so input keeps flowing until the pipeline is
// full. The user writes the mask, alpha and width registers through the cfg
// port only while no beat is in flight, not enforced; all reset to zero.
module mask_pixel_to_rgba8_unit import mpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      pixel_word,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic [7:0]       alpha_out
);

	mpr_cfg_t       cfg_q;
	logic           mid_valid;
	logic           mid_ready;
	mpr_scale_vec_t mid_lanes;
	mpr_chan_vec_t  chan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RED_MASK:      cfg_q.mask[CH_RED]   <= cfg_data;
				REG_GREEN_MASK:    cfg_q.mask[CH_GREEN] <= cfg_data;
				REG_BLUE_MASK:     cfg_q.mask[CH_BLUE]  <= cfg_data;
				REG_ALPHA_MASK:    cfg_q.mask[CH_ALPHA] <= cfg_data;
				REG_ALPHA_PRESENT: cfg_q.alpha_present  <= cfg_data[0];
				REG_BPP:           cfg_q.bpp            <= cfg_data[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	mpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_word (pixel_word),
		.out_valid  (mid_valid),
		.out_ready  (mid_ready),
		.out_lanes  (mid_lanes)
	);

	mpr_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_lanes  (mid_lanes),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_chan  (chan)
	);

	assign red_out   = chan[CH_RED];
	assign green_out = chan[CH_GREEN];
	assign blue_out  = chan[CH_BLUE];
	assign alpha_out = chan[CH_ALPHA];

	// With the sink taking beats, every stage moves, so input is never held off.
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input held off while output drains");

endmodule
